// ----- rtl/mma_pkg.sv -----
// Shared types and codes of the nine-channel moving average block.
// Used by multichannel_moving_average_top; depends on nothing else.
package mma_pkg;

    localparam int NCHAN  = 9;
    localparam int DATA_W = 16;

    // Operation codes carried on the func field
    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_AVG   = 1'b1;

    typedef logic signed [DATA_W-1:0] sample_t;

    // One ring slot: all channels side by side, channel 0 in the low bits
    typedef logic [NCHAN-1:0][DATA_W-1:0] row_t;

endpackage

// ----- rtl/multichannel_moving_average_top.sv -----
// Nine-channel boxcar average: a store is taken without leaving idle and gives no result.
// An average runs ST_SUM, ST_LAST, ST_MUL and ST_DIV for each channel in turn, then raises
// m_valid in ST_OUT until m_ready; no new input is taken before that result is delivered.
// One shared adder folds one ring slot per cycle; one reciprocal multiply per channel divides.
// Reset (aresetn low, synchronous) clears the slot valid bits and write slot, so the ring
// reads as all zero at once with no clearing pass. Depends on mma_pkg.
module multichannel_moving_average_top #(
    parameter int WINDOW = 10
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_func,
    input  logic signed [15:0]      s_chan_0,
    input  logic signed [15:0]      s_chan_1,
    input  logic signed [15:0]      s_chan_2,
    input  logic signed [15:0]      s_chan_3,
    input  logic signed [15:0]      s_chan_4,
    input  logic signed [15:0]      s_chan_5,
    input  logic signed [15:0]      s_chan_6,
    input  logic signed [15:0]      s_chan_7,
    input  logic signed [15:0]      s_chan_8,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [15:0]      m_avg_0,
    output logic signed [15:0]      m_avg_1,
    output logic signed [15:0]      m_avg_2,
    output logic signed [15:0]      m_avg_3,
    output logic signed [15:0]      m_avg_4,
    output logic signed [15:0]      m_avg_5,
    output logic signed [15:0]      m_avg_6,
    output logic signed [15:0]      m_avg_7,
    output logic signed [15:0]      m_avg_8
);

    localparam int DW    = mma_pkg::DATA_W;
    localparam int NCH   = mma_pkg::NCHAN;
    localparam int SLOTW = $clog2(WINDOW);
    localparam int CHW   = $clog2(NCH);
    // Sum of WINDOW signed samples; its magnitude fits the same width unsigned
    localparam int SUMW  = DW + SLOTW;
    // Exact floor(m / WINDOW) = (m * RECIP) >> SHIFT for every m < 2**SUMW
    localparam int SHIFT = SUMW + SLOTW;
    localparam int RW    = SUMW + 1;
    localparam int PW    = SUMW + RW;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [RW-1:0]    RECIP    = RW'(RECIP_FULL);
    localparam logic [SLOTW-1:0] LAST_SLOT = SLOTW'(WINDOW - 1);
    localparam logic [CHW-1:0]   LAST_CHAN = CHW'(NCH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_LAST,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                 state_reg, state_next;
    logic [SLOTW-1:0]       write_slot_reg, write_slot_next;
    logic [WINDOW-1:0]      slot_ok_reg, slot_ok_next;
    logic [SLOTW-1:0]       slot_cnt_reg, slot_cnt_next;
    logic [CHW-1:0]         chan_reg, chan_next;
    logic                   rd_live_reg, rd_live_next;
    logic signed [SUMW-1:0] acc_reg, acc_next;
    logic [PW-1:0]          prod_reg, prod_next;
    logic                   neg_reg, neg_next;
    mma_pkg::sample_t       avg_reg [NCH];
    mma_pkg::sample_t       avg_next [NCH];

    // Ring memory and its registered read port
    mma_pkg::row_t          ring_mem [WINDOW];
    mma_pkg::row_t          rd_row_reg;
    logic                   rd_ok_reg;

    logic                   s_fire;
    logic                   store_fire;
    mma_pkg::row_t          wr_row;
    logic [DW-1:0]          tap;
    logic [SUMW-1:0]        mag;
    logic [DW-1:0]          quot;

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = (state_reg == ST_OUT);
    assign s_fire     = s_valid && s_ready;
    assign store_fire = s_fire && (s_func == mma_pkg::FUNC_STORE);

    assign wr_row = {s_chan_8, s_chan_7, s_chan_6, s_chan_5, s_chan_4,
                     s_chan_3, s_chan_2, s_chan_1, s_chan_0};

    // Write one slot per store, read one slot per summing cycle
    always_ff @(posedge aclk) begin
        if (store_fire) begin
            ring_mem[write_slot_reg] <= wr_row;
        end
        if (state_reg == ST_SUM) begin
            rd_row_reg <= ring_mem[slot_cnt_reg];
            rd_ok_reg  <= slot_ok_reg[slot_cnt_reg];
        end
    end

    // Pick the current channel; a never-written slot counts as zero
    assign tap  = rd_ok_reg ? rd_row_reg[chan_reg] : '0;
    assign mag  = acc_reg[SUMW-1] ? (~acc_reg + SUMW'(1)) : acc_reg;
    assign quot = prod_reg[SHIFT +: DW];

    // Sequencer: accumulate, multiply by reciprocal, fix sign, next channel
    always_comb begin
        state_next      = state_reg;
        write_slot_next = write_slot_reg;
        slot_ok_next    = slot_ok_reg;
        slot_cnt_next   = slot_cnt_reg;
        chan_next       = chan_reg;
        rd_live_next    = 1'b0;
        acc_next        = acc_reg;
        prod_next       = prod_reg;
        neg_next        = neg_reg;
        avg_next        = avg_reg;

        // Shared adder: fold in the slot read last cycle
        if (rd_live_reg) begin
            acc_next = acc_reg + {{(SUMW-DW){tap[DW-1]}}, tap};
        end

        case (state_reg)
            ST_IDLE: begin
                if (store_fire) begin
                    slot_ok_next[write_slot_reg] = 1'b1;
                    write_slot_next = (write_slot_reg == LAST_SLOT) ? '0
                                      : write_slot_reg + SLOTW'(1);
                end else if (s_fire) begin
                    chan_next     = '0;
                    slot_cnt_next = '0;
                    acc_next      = '0;
                    state_next    = ST_SUM;
                end
            end
            ST_SUM: begin
                rd_live_next = 1'b1;
                if (slot_cnt_reg == LAST_SLOT) begin
                    state_next = ST_LAST;
                end else begin
                    slot_cnt_next = slot_cnt_reg + SLOTW'(1);
                end
            end
            ST_LAST: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                prod_next  = PW'(mag) * PW'(RECIP);
                neg_next   = acc_reg[SUMW-1];
                state_next = ST_DIV;
            end
            ST_DIV: begin
                avg_next[chan_reg] = neg_reg ? (~quot + DW'(1)) : quot;
                if (chan_reg == LAST_CHAN) begin
                    state_next = ST_OUT;
                end else begin
                    chan_next     = chan_reg + CHW'(1);
                    slot_cnt_next = '0;
                    acc_next      = '0;
                    state_next    = ST_SUM;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            write_slot_reg <= '0;
            slot_ok_reg    <= '0;
            rd_live_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            write_slot_reg <= write_slot_next;
            slot_ok_reg    <= slot_ok_next;
            rd_live_reg    <= rd_live_next;
        end
        slot_cnt_reg <= slot_cnt_next;
        chan_reg     <= chan_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
        avg_reg      <= avg_next;
    end

    assign m_avg_0 = avg_reg[0];
    assign m_avg_1 = avg_reg[1];
    assign m_avg_2 = avg_reg[2];
    assign m_avg_3 = avg_reg[3];
    assign m_avg_4 = avg_reg[4];
    assign m_avg_5 = avg_reg[5];
    assign m_avg_6 = avg_reg[6];
    assign m_avg_7 = avg_reg[7];
    assign m_avg_8 = avg_reg[8];

    // Input and result sides are never open together
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // A store finishes in its own cycle
    a_store: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_func == mma_pkg::FUNC_STORE) |=> s_ready)
        else $error("store transaction blocked the input");

    // An average request holds off further input
    a_avg: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_func == mma_pkg::FUNC_AVG) |=> !s_ready)
        else $error("average request did not start the sequencer");

    // Delivering the result reopens the input
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> (s_ready && !m_valid))
        else $error("result transaction did not return to idle");

    // Write slot stays inside the ring
    a_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        write_slot_reg <= LAST_SLOT)
        else $error("write slot out of range");

endmodule

// ----- tb/sv/tb_multichannel_moving_average_top.sv -----
// Self-checking testbench for multichannel_moving_average_top: directed and random
// store/average transactions against an in-bench window model, random stalls on both sides.
// Depends on mma_pkg and multichannel_moving_average_top.
module tb_multichannel_moving_average_top;

    localparam int WINDOW     = 10;
    localparam int LATENCY    = 9 * (WINDOW + 3) + 1;
    localparam int STALL_MAX  = 4000;
    localparam int RAND_ITEMS = 600;
    localparam int IDLE_PCT   = 24;

    typedef struct packed {
        logic          func;
        mma_pkg::row_t chans;
    } sample_set_t;

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_func  = mma_pkg::FUNC_STORE;
    mma_pkg::row_t s_row   = '0;
    logic          m_ready = 1'b0;
    logic          s_ready;
    logic          m_valid;
    wire [mma_pkg::NCHAN-1:0][mma_pkg::DATA_W-1:0] m_row;

    // Pending input transactions and the averages still owed by the block
    sample_set_t   pending[$];
    mma_pkg::row_t mean_q[$];

    // Window model: one row of channel samples per slot
    mma_pkg::row_t hist_ring[WINDOW];
    int   hist_slot = 0;

    int   cyc          = 0;
    int   stall_cycles = 0;
    int   err_count    = 0;
    int   n_stores     = 0;
    int   n_means      = 0;
    int   n_checked    = 0;

    multichannel_moving_average_top #(.WINDOW(WINDOW)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .s_chan_0(s_row[0]),
        .s_chan_1(s_row[1]),
        .s_chan_2(s_row[2]),
        .s_chan_3(s_row[3]),
        .s_chan_4(s_row[4]),
        .s_chan_5(s_row[5]),
        .s_chan_6(s_row[6]),
        .s_chan_7(s_row[7]),
        .s_chan_8(s_row[8]),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_avg_0 (m_row[0]),
        .m_avg_1 (m_row[1]),
        .m_avg_2 (m_row[2]),
        .m_avg_3 (m_row[3]),
        .m_avg_4 (m_row[4]),
        .m_avg_5 (m_row[5]),
        .m_avg_6 (m_row[6]),
        .m_avg_7 (m_row[7]),
        .m_avg_8 (m_row[8])
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Sum each channel over the whole ring, divide by the window, truncate toward zero
    function automatic mma_pkg::row_t window_means();
        mma_pkg::row_t means;
        int   sum;
        int   q;
        for (int c = 0; c < mma_pkg::NCHAN; c++) begin
            sum = 0;
            for (int s = 0; s < WINDOW; s++) begin
                sum = sum + $signed(hist_ring[s][c]);
            end
            q = sum / WINDOW;
            means[c] = q[mma_pkg::DATA_W-1:0];
        end
        return means;
    endfunction

    function automatic mma_pkg::row_t same_row(logic [mma_pkg::DATA_W-1:0] v);
        mma_pkg::row_t r;
        for (int c = 0; c < mma_pkg::NCHAN; c++) begin
            r[c] = v;
        end
        return r;
    endfunction

    // Bias toward the extremes and small values around zero
    function automatic logic [mma_pkg::DATA_W-1:0] pick_sample();
        int v;
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: begin
                v = $urandom_range(40);
                v = v - 20;
                return v[mma_pkg::DATA_W-1:0];
            end
            default: begin
                v = $urandom();
                return v[mma_pkg::DATA_W-1:0];
            end
        endcase
    endfunction

    task automatic queue_item(logic f, mma_pkg::row_t r);
        sample_set_t it;
        it.func  = f;
        it.chans = r;
        pending.push_back(it);
    endtask

    task automatic flag_mismatch(string what, int idx, logic [mma_pkg::DATA_W-1:0] got,
                                 logic [mma_pkg::DATA_W-1:0] want);
        $display("MISMATCH %s avg_%0d: got %0d expected %0d at cycle %0d",
                 what, idx, $signed(got), $signed(want), cyc);
        err_count++;
    endtask

    // Idle-free stretch in the middle of the run
    function automatic bit steady();
        return (cyc >= 6000) && (cyc < 14000);
    endfunction

    always @(posedge aclk) begin
        cyc <= cyc + 1;
    end

    // Driver: present the next pending transaction once the slot is free
    always @(posedge aclk) begin
        sample_set_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending.size() != 0 && (steady() || $urandom_range(99) >= IDLE_PCT)) begin
                it = pending.pop_front();
                s_valid <= 1'b1;
                s_func  <= it.func;
                s_row   <= it.chans;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure
    always @(posedge aclk) begin
        m_ready <= steady() || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: check results, update the window model, watch for a hang
    always @(posedge aclk) begin
        mma_pkg::row_t want;
        bit   moved;
        if (aresetn) begin
            moved = 1'b0;
            if (m_valid && m_ready) begin
                moved = 1'b1;
                if (mean_q.size() == 0) begin
                    flag_mismatch("unexpected result", 0, m_row[0], '0);
                end else begin
                    want = mean_q.pop_front();
                    n_checked++;
                    for (int c = 0; c < mma_pkg::NCHAN; c++) begin
                        if (m_row[c] !== want[c]) begin
                            flag_mismatch("field", c, m_row[c], want[c]);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                moved = 1'b1;
                if (s_func == mma_pkg::FUNC_STORE) begin
                    hist_ring[hist_slot] = s_row;
                    hist_slot = (hist_slot == WINDOW - 1) ? 0 : hist_slot + 1;
                    n_stores++;
                end else begin
                    mean_q.push_back(window_means());
                    n_means++;
                end
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_MAX) begin
                $display("Timeout: no transaction for %0d cycles", STALL_MAX);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        mma_pkg::row_t mix;
        for (int s = 0; s < WINDOW; s++) begin
            hist_ring[s] = '0;
        end

        // Average on the cleared ring, then a partly filled window with mixed signs
        queue_item(mma_pkg::FUNC_AVG, same_row(16'h1234));
        mix[0] = 16'h7FFF;
        mix[1] = 16'h8000;
        mix[2] = -16'sd7;
        mix[3] = 16'sd7;
        mix[4] = 16'sd15;
        mix[5] = -16'sd15;
        mix[6] = 16'sd1;
        mix[7] = -16'sd1;
        mix[8] = 16'sd0;
        queue_item(mma_pkg::FUNC_STORE, mix);
        queue_item(mma_pkg::FUNC_AVG, '0);
        queue_item(mma_pkg::FUNC_STORE, same_row(16'h5555));
        queue_item(mma_pkg::FUNC_STORE, same_row(16'hAAAA));
        queue_item(mma_pkg::FUNC_AVG, same_row(16'hFFFF));
        // Fill the whole ring with the most negative value, wrapping the write slot
        for (int i = 0; i < WINDOW; i++) begin
            queue_item(mma_pkg::FUNC_STORE, same_row(16'h8000));
        end
        queue_item(mma_pkg::FUNC_AVG, '0);
        queue_item(mma_pkg::FUNC_STORE, same_row(16'h7FFF));
        queue_item(mma_pkg::FUNC_AVG, same_row(16'h8000));

        // Random mix of stores and averages
        for (int i = 0; i < RAND_ITEMS; i++) begin
            for (int c = 0; c < mma_pkg::NCHAN; c++) begin
                mix[c] = pick_sample();
            end
            queue_item(($urandom_range(99) < 35) ? mma_pkg::FUNC_AVG : mma_pkg::FUNC_STORE,
                       mix);
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain input, then the owed averages, then let the pipeline settle
        while (pending.size() != 0 || s_valid) @(posedge aclk);
        while (mean_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);

        $display("Run covered %0d store and %0d average transactions, %0d averages compared.",
                 n_stores, n_means, n_checked);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
